/* rtl/linear_probe_hash_table_core_assert.svh */
// Assertion macros for the linear probing hash table.
// Included by the top level; the synthesis build gets empty definitions.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht assertion failed");
// Next-cycle implication.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");
`else
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lpht_pkg.sv */
// Shared constants and types of the linear probing hash table.
// No dependencies; used by the interfaces, the hash unit and the top level.
package lpht_pkg;

    localparam int TABLE_SIZE = 13;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 32;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 3;
    localparam int SIDX_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SEARCH = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_BUSY    = 2'd1,
        SLOT_REMOVED = 2'd2
    } t_slot_state;

    typedef enum logic [STAT_W-1:0] {
        ST_CLEARED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FOUND     = 3'd5,
        ST_NOT_FOUND = 3'd6
    } t_status;

    typedef struct packed {
        t_slot_state        state;
        logic [KEY_W-1:0]   key;
    } t_slot;

endpackage

/* rtl/lpht_req_if.sv */
// Request channel of the linear probing hash table.
// Depends on lpht_pkg for the field widths.
interface lpht_req_if
    import lpht_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [KEY_W-1:0]   key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

/* rtl/lpht_rsp_if.sv */
// Response channel of the linear probing hash table.
// Depends on lpht_pkg for the field widths.
interface lpht_rsp_if
    import lpht_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [SIDX_W-1:0]  slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

/* rtl/linear_probe_hash_table_core.sv */
// Linear probing hash table core: control sequencer and slot memory.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_mod and the assertion header.
//
// Requests arrive on i_req (opcode, key) and are taken when valid and ready are
// both high. Each request yields exactly one response on o_rsp (status,
// slot_index), held in an output register until the receiver takes it.
// The core handles one request at a time; ready is high only while it idles.
// A clear goes straight to the final state, from which its response
// is loaded into the output register. Insert, remove and search first
// compute the home slot in the pipelined modulo unit, then probe one
// slot per cycle through the slot memory, whose read is registered.
// An operation probes 1 to TABLE_SIZE slots, at most 13 for a table of
// 13 slots. A clear takes effect at once through a per-slot valid
// vector, so neither reset nor clear needs a pass over the memory.
// Reset leaves every slot free and the core idle with no response pending.
// When the receiver stalls, the finished result stays in the output register
// and the next request is still accepted; a later result waits in the
// sequencer until the output register is free.
`include "linear_probe_hash_table_core_assert.svh"

module linear_probe_hash_table_core
    import lpht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpht_req_if.sink    i_req,
    lpht_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FIN
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    t_state              r_state;
    t_opcode             r_op;
    logic [KEY_W-1:0]    r_key;
    logic [IDX_W-1:0]    r_pos;
    logic [IDX_W-1:0]    r_cnt;
    t_status             r_res_status;
    logic [SIDX_W-1:0]   r_res_idx;
    logic                r_out_vld;
    t_status             r_out_status;
    logic [SIDX_W-1:0]   r_out_idx;

    // Slot memory: state and key of each slot, plus a valid vector that
    // makes never-written or cleared slots read as free.
    t_slot               mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_slot_vld;
    t_slot               r_rd_data;
    logic                r_rd_vld;

    logic                req_acc;
    logic                clr;
    logic                mod_start;
    logic                mod_done;
    logic [IDX_W-1:0]    mod_rem;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    t_slot               wr_data;

    logic                slot_busy;
    logic                slot_hit;
    logic                probe_last;
    logic [IDX_W-1:0]    next_pos;
    logic                fin;
    t_status             fin_status;
    logic [SIDX_W-1:0]   fin_idx;
    logic                out_load;

    assign req_acc   = i_req.valid && i_req.ready;
    assign clr       = req_acc && (t_opcode'(i_req.opcode) == OP_CLEAR);
    assign mod_start = req_acc && (t_opcode'(i_req.opcode) != OP_CLEAR);

    lpht_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_req.key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // The slot read in the previous cycle, with invalid slots seen as free.
    assign slot_busy  = r_rd_vld && (r_rd_data.state == SLOT_BUSY);
    assign slot_hit   = slot_busy && (r_rd_data.key == r_key);
    assign probe_last = (r_cnt == LAST_IDX);
    assign next_pos   = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;

    // The finished result moves to the output register once it is free.
    assign out_load   = (r_state == S_FIN) && (!r_out_vld || o_rsp.ready);

    // Probe decision. The memory is written only in the cycle that ends an
    // operation, and the next read comes many cycles later, so a read never
    // meets a write to the same slot in flight.
    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = next_pos;
        mem_we     = 1'b0;
        wr_addr    = r_pos;
        wr_data    = '{state: SLOT_BUSY, key: r_key};
        fin        = 1'b0;
        fin_status = ST_NOT_FOUND;
        fin_idx    = '0;
        case (r_state)
            S_HASH: begin
                rd_addr = mod_rem;
                rd_en   = mod_done;
            end
            S_PROBE: begin
                if (r_op == OP_INSERT) begin
                    if (slot_hit) begin
                        fin        = 1'b1;
                        fin_status = ST_DUPLICATE;
                    end else if (!slot_busy) begin
                        mem_we     = 1'b1;
                        fin        = 1'b1;
                        fin_status = ST_INSERTED;
                        fin_idx    = SIDX_W'(r_pos);
                    end else if (probe_last) begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                    end else begin
                        rd_en = 1'b1;
                    end
                end else begin
                    if (slot_hit) begin
                        fin     = 1'b1;
                        fin_idx = SIDX_W'(r_pos);
                        if (r_op == OP_REMOVE) begin
                            mem_we        = 1'b1;
                            wr_data.state = SLOT_REMOVED;
                            fin_status    = ST_REMOVED;
                        end else begin
                            fin_status = ST_FOUND;
                        end
                    end else if (probe_last) begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_FOUND;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Slot memory array, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Valid vector: reset and clear free every slot at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (clr) begin
            r_slot_vld <= '0;
        end else if (mem_we) begin
            r_slot_vld[wr_addr] <= 1'b1;
        end
        if (rd_en) begin
            r_rd_vld <= r_slot_vld[rd_addr];
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_op  <= t_opcode'(i_req.opcode);
                        r_key <= i_req.key;
                        if (clr) begin
                            r_res_status <= ST_CLEARED;
                            r_res_idx    <= '0;
                            r_state      <= S_FIN;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (mod_done) begin
                        r_pos   <= mod_rem;
                        r_cnt   <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (fin) begin
                        r_res_status <= fin_status;
                        r_res_idx    <= fin_idx;
                        r_state      <= S_FIN;
                    end else if (rd_en) begin
                        r_pos <= next_pos;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out_status <= r_res_status;
                        r_out_idx    <= r_res_idx;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_index = r_out_idx;

    // A taken request keeps the core busy in the following cycle.
    `LPHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, req_acc, !i_req.ready)
    // The home slot arrives only while the sequencer waits for it, and in range.
    `LPHT_ASSERT_IMPL(a_hash_in_wait, i_clk, i_rst_n, mod_done, r_state == S_HASH)
    `LPHT_ASSERT_IMPL(a_home_in_range, i_clk, i_rst_n, mod_done, mod_rem <= LAST_IDX)
    // A slot write always leaves that slot valid.
    `LPHT_ASSERT_NEXT(a_write_sets_valid, i_clk, i_rst_n, mem_we, r_slot_vld[$past(wr_addr)])

endmodule

/* rtl/lpht_mod.sv */
// Home slot unit: key modulo TABLE_SIZE in three pipelined steps.
// Depends on lpht_pkg.
module lpht_mod
    import lpht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [KEY_W-1:0]   i_key,
    output logic               o_done,
    output logic [IDX_W-1:0]   o_rem
);

    // Key chunks are 12, 12 and 8 bits wide. Their weights 2^12 and 2^24 are
    // reduced modulo TABLE_SIZE, which leaves a congruent sum below 2^21.
    localparam int SUM_W  = 24;
    localparam int PROD_W = SUM_W + 32;
    localparam int W1     = (1 << 12) % TABLE_SIZE;
    localparam int W2     = (W1 * W1) % TABLE_SIZE;
    // Reciprocal of TABLE_SIZE scaled by 2^32 and rounded up. The quotient
    // it gives is exact for every sum below 2^24.
    localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'd1 << 32) / 64'(TABLE_SIZE) + 64'd1);

    logic               r_v1;
    logic               r_v2;
    logic               r_done;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   r_sum2;
    logic [SUM_W-1:0]   r_q;
    logic [IDX_W-1:0]   r_rem;

    logic [SUM_W-1:0]   chunk_sum;
    logic [PROD_W-1:0]  prod;
    logic [SUM_W-1:0]   qn;
    logic [SUM_W-1:0]   diff;

    assign chunk_sum = SUM_W'(i_key[11:0])
                     + SUM_W'(i_key[23:12]) * SUM_W'(W1)
                     + SUM_W'(i_key[31:24]) * SUM_W'(W2);
    assign prod      = PROD_W'(r_sum) * RECIP;
    assign qn        = r_q * SUM_W'(TABLE_SIZE);
    assign diff      = r_sum2 - qn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= chunk_sum;
        end
        if (r_v1) begin
            r_q    <= prod[PROD_W-1:32];
            r_sum2 <= r_sum;
        end
        if (r_v2) begin
            r_rem <= diff[IDX_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
